// File: hw/rtl/pctf_pkg.sv
// pctf_pkg: shared types and codes for the productive countdown timer
package pctf_pkg;

  // mode codes, also the state machine of the timer
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_SET   = 3'd1,
    MODE_COUNT = 3'd2,
    MODE_PAUSE = 3'd3,
    MODE_STAT  = 3'd4
  } mode_t;

  // event codes carried by a request
  localparam logic [2:0] OP_INC   = 3'd0;
  localparam logic [2:0] OP_DEC   = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_ABORT = 3'd4;

  // result status codes
  localparam logic [1:0] ST_IGNORED    = 2'd0;
  localparam logic [1:0] ST_HANDLED    = 2'd1;
  localparam logic [1:0] ST_TRANSITION = 2'd2;

  // entry message codes
  localparam logic [1:0] MSG_NONE  = 2'd0;
  localparam logic [1:0] MSG_SET   = 2'd1;
  localparam logic [1:0] MSG_PROD  = 2'd2;
  localparam logic [1:0] MSG_PAUSE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_SECONDS     = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd1;
  localparam logic [1:0] CFG_STAT_HOLD_TICKS  = 2'd2;
  localparam logic [1:0] CFG_BEEP_SUBSECOND   = 2'd3;

  // configuration reset values
  localparam logic [11:0] RST_STEP_SECONDS     = 12'd60;
  localparam logic [7:0]  RST_TICKS_PER_SECOND = 8'd10;
  localparam logic [7:0]  RST_STAT_HOLD_TICKS  = 8'd30;
  localparam logic [7:0]  RST_BEEP_SUBSECOND   = 8'd5;

  localparam logic [15:0] SEC_MAX  = 16'hFFFF;
  localparam logic [31:0] PROD_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] subsecond;
  } req_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  status;
    logic        beep;
    logic [31:0] display_value;
    logic [1:0]  message;
  } rsp_t;

  typedef struct packed {
    logic [11:0] step_seconds;
    logic [7:0]  ticks_per_second;
    logic [7:0]  stat_hold_ticks;
    logic [7:0]  beep_subsecond;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] set_seconds;
    logic [15:0] elapsed_seconds;
    logic [31:0] productive_seconds;
    logic [7:0]  countdown_divider;
    logic [7:0]  stat_divider;
  } timer_state_t;

endpackage

// File: hw/rtl/pctf_step.sv
// pctf_step: one event applied to the timer state, with mode exit and entry actions
module pctf_step (
  input  pctf_pkg::timer_state_t state,
  input  pctf_pkg::cfg_t         cfg,
  input  pctf_pkg::req_t         req,
  output pctf_pkg::timer_state_t state_nxt,
  output pctf_pkg::rsp_t         rsp
);
  import pctf_pkg::*;

  logic [16:0] add_sum;
  logic [15:0] set_add;
  logic        can_dec;
  logic [15:0] set_sub;
  logic [7:0]  cd_inc;
  logic        cd_fire;
  logic [15:0] set_tick;
  logic [15:0] elapsed_tick;
  logic [7:0]  st_inc;
  logic        st_fire;
  logic        beep_hit;
  logic [32:0] prod_sum;
  mode_t       dst;

  // shared arithmetic
  assign add_sum      = {1'b0, state.set_seconds} + {5'd0, cfg.step_seconds};
  assign set_add      = add_sum[16] ? SEC_MAX : add_sum[15:0];
  assign can_dec      = state.set_seconds >= {4'd0, cfg.step_seconds};
  assign set_sub      = state.set_seconds - {4'd0, cfg.step_seconds};
  assign cd_inc       = state.countdown_divider + 8'd1;
  assign cd_fire      = cd_inc >= cfg.ticks_per_second;
  assign set_tick     = (state.set_seconds != 16'd0) ? state.set_seconds - 16'd1 : 16'd0;
  assign elapsed_tick = (state.elapsed_seconds != SEC_MAX) ?
                        state.elapsed_seconds + 16'd1 : SEC_MAX;
  assign st_inc       = state.stat_divider + 8'd1;
  assign st_fire      = st_inc >= cfg.stat_hold_ticks;
  assign beep_hit     = req.subsecond == cfg.beep_subsecond;

  // next mode
  always_comb begin
    dst = state.mode;
    unique case (state.mode)
      MODE_IDLE: begin
        if (req.operation == OP_INC) dst = MODE_SET;
        else if (req.operation == OP_START) dst = MODE_STAT;
      end
      MODE_SET: begin
        if (req.operation == OP_ABORT) dst = MODE_IDLE;
        else if (req.operation == OP_START && can_dec) dst = MODE_COUNT;
      end
      MODE_COUNT: begin
        if (req.operation == OP_TICK && cd_fire && set_tick == 16'd0) dst = MODE_IDLE;
        else if (req.operation == OP_START) dst = MODE_PAUSE;
        else if (req.operation == OP_ABORT) dst = MODE_IDLE;
      end
      MODE_PAUSE: begin
        if (req.operation == OP_INC) dst = MODE_SET;
        else if (req.operation == OP_DEC && can_dec) dst = MODE_SET;
        else if (req.operation == OP_START) dst = MODE_COUNT;
        else if (req.operation == OP_ABORT) dst = MODE_IDLE;
      end
      MODE_STAT: begin
        if (req.operation == OP_TICK && st_fire) dst = MODE_IDLE;
      end
      default: dst = state.mode;
    endcase
  end

  // datapath and result
  always_comb begin
    state_nxt      = state;
    state_nxt.mode = dst;
    rsp            = '0;
    rsp.status     = ST_IGNORED;
    rsp.message    = MSG_NONE;

    unique case (state.mode)
      MODE_IDLE: begin
        if (req.operation == OP_INC) begin
          state_nxt.set_seconds = set_add;
        end else if (req.operation == OP_TICK && beep_hit) begin
          rsp.beep   = 1'b1;
          rsp.status = ST_HANDLED;
        end
      end
      MODE_SET: begin
        if (req.operation == OP_INC) begin
          state_nxt.set_seconds = set_add;
          rsp.status            = ST_HANDLED;
        end else if (req.operation == OP_DEC && can_dec) begin
          state_nxt.set_seconds = set_sub;
          rsp.status            = ST_HANDLED;
        end
      end
      MODE_COUNT: begin
        if (req.operation == OP_TICK) begin
          state_nxt.countdown_divider = cd_fire ? 8'd0 : cd_inc;
          if (cd_fire) begin
            state_nxt.set_seconds     = set_tick;
            state_nxt.elapsed_seconds = elapsed_tick;
            rsp.status                = ST_HANDLED;
          end
        end
      end
      MODE_PAUSE: begin
        if (req.operation == OP_INC) state_nxt.set_seconds = set_add;
        else if (req.operation == OP_DEC && can_dec) state_nxt.set_seconds = set_sub;
      end
      MODE_STAT: begin
        if (req.operation == OP_TICK) state_nxt.stat_divider = st_fire ? 8'd0 : st_inc;
      end
      default: ;
    endcase

    // exit and entry actions
    prod_sum = {1'b0, state.productive_seconds} + {17'd0, state_nxt.elapsed_seconds};
    if (dst != state.mode) begin
      rsp.status = ST_TRANSITION;
      if (state.mode == MODE_COUNT) begin
        state_nxt.productive_seconds = prod_sum[32] ? PROD_MAX : prod_sum[31:0];
        state_nxt.elapsed_seconds    = 16'd0;
      end
      if (dst == MODE_IDLE) begin
        state_nxt.set_seconds     = 16'd0;
        state_nxt.elapsed_seconds = 16'd0;
        rsp.message               = MSG_SET;
      end else if (dst == MODE_STAT) begin
        rsp.message = MSG_PROD;
      end else if (dst == MODE_PAUSE) begin
        rsp.message = MSG_PAUSE;
      end
    end

    rsp.mode          = dst;
    rsp.display_value = (dst == MODE_STAT) ? state_nxt.productive_seconds :
                        {16'd0, state_nxt.set_seconds};
  end

endmodule

// File: hw/rtl/productive_countdown_timer_fsm_core.sv
// productive_countdown_timer_fsm_core: five-mode countdown timer with productive time total
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in_     | input     | in_valid/in_stall  | pctf_pkg::req_t (operation, subsecond)
//   out_    | output    | out_valid/out_stall| pctf_pkg::rsp_t (mode .. message)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// each accepted request is applied to the state registers and its result is
// captured in the output register at the same edge
// a new request is taken every cycle while the result register is empty or draining
// in_stall is high only while a result sits in the output register under out_stall
// rst_n (synchronous) returns to idle with all counters zero and config at defaults
// cfg_ready is always high; config is to be written between requests, the block does not enforce it
module productive_countdown_timer_fsm_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pctf_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output pctf_pkg::rsp_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [11:0]     cfg_data
);
  import pctf_pkg::*;

  cfg_t         cfg_r;
  cfg_t         cfg_nxt;
  timer_state_t state_r;
  timer_state_t state_nxt;
  rsp_t         rsp;
  rsp_t         out_data_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         in_acc;

  // request is accepted when the result register is free or being taken
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_SECONDS:     cfg_nxt.step_seconds     = cfg_data;
        CFG_TICKS_PER_SECOND: cfg_nxt.ticks_per_second = cfg_data[7:0];
        CFG_STAT_HOLD_TICKS:  cfg_nxt.stat_hold_ticks  = cfg_data[7:0];
        CFG_BEEP_SUBSECOND:   cfg_nxt.beep_subsecond   = cfg_data[7:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  // event logic: next timer state and the result of this request
  pctf_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .req       (in_data),
    .state_nxt (state_nxt),
    .rsp       (rsp)
  );

  // result register valid: set by an accepted request, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_seconds     <= RST_STEP_SECONDS;
      cfg_r.ticks_per_second <= RST_TICKS_PER_SECOND;
      cfg_r.stat_hold_ticks  <= RST_STAT_HOLD_TICKS;
      cfg_r.beep_subsecond   <= RST_BEEP_SUBSECOND;
      state_r.mode               <= MODE_IDLE;
      state_r.set_seconds        <= 16'd0;
      state_r.elapsed_seconds    <= 16'd0;
      state_r.productive_seconds <= 32'd0;
      state_r.countdown_divider  <= 8'd0;
      state_r.stat_divider       <= 8'd0;
      out_valid_r                <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) state_r <= state_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= rsp;
  end

`ifndef SYNTHESIS
  // an accepted request always shows up as a result on the next cycle
  a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted request produced no result");

  // a pending result carries the mode now held in the state register
  a_rsp_mode_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode == state_r.mode)
    else $error("result mode differs from timer mode");

  // entry messages only come with a mode transition
  a_msg_on_transition: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.message != MSG_NONE) |-> out_data.status == ST_TRANSITION)
    else $error("entry message without transition");

  // elapsed time is folded into the total whenever countdown is left
  a_elapsed_only_counting: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode != MODE_COUNT |-> state_r.elapsed_seconds == 16'd0)
    else $error("elapsed time kept outside countdown");
`endif

endmodule
